// File: src/sha_pkg.sv
package sha_pkg;

  localparam int QDEPTH = 2;

  typedef logic [15:0][31:0] blk_t;

  typedef struct packed {
    logic fin;
    blk_t words;
  } job_t;

  localparam logic [7:0][31:0] IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] RC [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// File: src/sha256_stream_hasher_core.sv
// SHA-256 over a byte stream.
// Input: one transfer per item. in_tdata carries a message byte, in_tuser
// marks it as present, in_tlast ends the message after this item's byte.
// Output: eight transfers per message, digest words in big-endian order,
// out_tlast on the eighth.
// The front packs bytes at one per cycle while the queue has room and
// no padding is pending, and hands each full 64-byte block (and the one
// or two padding blocks) to a two-entry block queue; the back runs the
// 64 rounds at one per cycle and then folds the result into the hash.
// A block is drained from the queue as the back frees up, so bytes flow
// at one per cycle until the queue fills.
// After in_tlast the front pushes one or two padding blocks; the back
// hashes each remaining block, then loads the digest for output.
// Reset (rst_n low, synchronous) empties the queue, clears the byte count
// and loads the initial hash values. If the receiver stalls, digest words
// wait in their register; the back stops before the next message's digest
// and the front stops once the queue is full.
module sha256_stream_hasher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_valid
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index
  output logic        out_tlast
);

  sha_pkg::job_t push_job, pop_job;
  logic          push, pop, q_full, q_empty;
  logic [31:0]   dword;
  logic [2:0]    widx;

  sha_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .data_byte  (in_tdata),
    .byte_valid (in_tuser),
    .eom        (in_tlast),
    .push       (push),
    .job        (push_job),
    .q_full     (q_full)
  );

  sha_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (push_job),
    .pop    (pop),
    .rd_job (pop_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  sha_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_job       (pop_job),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .digest_word (dword),
    .word_index  (widx),
    .last_word   (out_tlast)
  );

  assign out_tdata = {5'b00000, widx, dword};

endmodule

// File: src/sha_front.sv
module sha_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      data_byte,
  input  logic            byte_valid,
  input  logic            eom,
  output logic            push,
  output sha_pkg::job_t   job,
  input  logic            q_full
);

  typedef enum logic [1:0] {F_ACC, F_PAD, F_LEN} fstate_t;

  fstate_t        state_r, state_nxt;
  sha_pkg::blk_t  blk_r, blk_nxt;
  logic [60:0]    cnt_r, cnt_nxt;
  logic [63:0]    bits;

  function automatic sha_pkg::blk_t put_byte(sha_pkg::blk_t b, logic [5:0] pos,
                                             logic [7:0] d);
    sha_pkg::blk_t r;
    r = b;
    case (pos[1:0])
      2'd0:    r[pos[5:2]] = {d, 24'h0};
      2'd1:    r[pos[5:2]][23:16] = d;
      2'd2:    r[pos[5:2]][15:8] = d;
      default: r[pos[5:2]][7:0] = d;
    endcase
    return r;
  endfunction

  assign in_ready = (state_r == F_ACC) && !q_full;
  assign bits     = {cnt_r, 3'b000};

  always_comb begin
    state_nxt = state_r;
    blk_nxt   = blk_r;
    cnt_nxt   = cnt_r;
    push      = 1'b0;
    job.fin   = 1'b0;
    job.words = blk_r;
    unique case (state_r)
      F_ACC: begin
        if (in_valid && in_ready) begin
          if (byte_valid) begin
            blk_nxt = put_byte(blk_r, cnt_r[5:0], data_byte);
            cnt_nxt = cnt_r + 61'd1;
            if (cnt_nxt[5:0] == 6'd0) begin
              push      = 1'b1;
              job.words = blk_nxt;
            end
          end
          if (eom) state_nxt = F_PAD;
        end
      end
      F_PAD: begin
        blk_nxt = put_byte(blk_r, cnt_r[5:0], 8'h80);
        for (int i = 0; i < 16; i++) begin
          if (4'(i) > cnt_r[5:2]) blk_nxt[i] = '0;
        end
        if (cnt_r[5:0] < 6'd56) begin
          blk_nxt[14] = bits[63:32];
          blk_nxt[15] = bits[31:0];
          job.fin     = 1'b1;
        end
        job.words = blk_nxt;
        if (!q_full) begin
          push = 1'b1;
          if (cnt_r[5:0] < 6'd56) begin
            cnt_nxt   = '0;
            state_nxt = F_ACC;
          end else begin
            state_nxt = F_LEN;
          end
        end else begin
          blk_nxt = blk_r;
        end
      end
      default: begin
        blk_nxt     = '0;
        blk_nxt[14] = bits[63:32];
        blk_nxt[15] = bits[31:0];
        job.fin     = 1'b1;
        job.words   = blk_nxt;
        if (!q_full) begin
          push      = 1'b1;
          cnt_nxt   = '0;
          state_nxt = F_ACC;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_ACC;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    blk_r <= blk_nxt;
  end

endmodule

// File: src/sha_queue.sv
module sha_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sha_pkg::job_t wr_job,
  input  logic          pop,
  output sha_pkg::job_t rd_job,
  output logic          full,
  output logic          empty
);

  localparam int AW = (sha_pkg::QDEPTH > 1) ? $clog2(sha_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(sha_pkg::QDEPTH + 1);

  sha_pkg::job_t mem [sha_pkg::QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full   = (cnt_r == CW'(sha_pkg::QDEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_job = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(sha_pkg::QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(sha_pkg::QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
    if (push) mem[wp_r] <= wr_job;
  end

endmodule

// File: src/sha_back.sv
module sha_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  sha_pkg::job_t q_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   digest_word,
  output logic [2:0]    word_index,
  output logic          last_word
);

  typedef enum logic [1:0] {B_IDLE, B_RND, B_ADD, B_OUT} bstate_t;

  bstate_t              state_r;
  logic [7:0][31:0]     v_r, v_nxt, hash_r, dig_r;
  sha_pkg::blk_t        w_r;
  logic [31:0]          w_new, t1, t2, a, e;
  logic [5:0]           rnd_r;
  logic                 fin_r, obusy_r;
  logic [2:0]           oidx_r;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  assign pop         = (state_r == B_IDLE) && !q_empty;
  assign out_valid   = obusy_r;
  assign digest_word = dig_r[0];
  assign word_index  = oidx_r;
  assign last_word   = (oidx_r == 3'd7);

  always_comb begin
    a = v_r[0];
    e = v_r[4];
    w_new = w_r[0] + w_r[9]
          + (rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3))
          + (rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10));
    t1 = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
       + ((e & v_r[5]) ^ (~e & v_r[6])) + sha_pkg::RC[rnd_r] + w_r[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
       + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
    v_nxt    = {v_r[6:4], v_r[3] + t1, v_r[2:0], t1 + t2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      obusy_r  <= 1'b0;
      oidx_r   <= '0;
      hash_r   <= sha_pkg::IV;
    end else begin
      if (obusy_r && out_ready) begin
        dig_r  <= {32'h0, dig_r[7:1]};
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd7) obusy_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            w_r     <= q_job.words;
            fin_r   <= q_job.fin;
            v_r     <= hash_r;
            rnd_r   <= '0;
            state_r <= B_RND;
          end
        end
        B_RND: begin
          v_r   <= v_nxt;
          w_r   <= {w_new, w_r[15:1]};
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= B_ADD;
        end
        B_ADD: begin
          for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + v_r[i];
          state_r <= fin_r ? B_OUT : B_IDLE;
        end
        default: begin
          if (!obusy_r) begin
            dig_r   <= hash_r;
            obusy_r <= 1'b1;
            oidx_r  <= '0;
            hash_r  <= sha_pkg::IV;
            state_r <= B_IDLE;
          end
        end
      endcase
    end
  end

endmodule
